@@ hw/rtl/cbb_pkg.sv @@
// Shared types, constants and the cosine ROM generator of the Chebyshev basis evaluator.
package cbb_pkg;

  localparam int unsigned MAX_DEGREE_DEF = 31;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Shared serial divider: magnitudes up to 63 bits, iteration count up to 64
  localparam int unsigned DIV_W = 64;
  localparam int unsigned CNT_W = 7;

  localparam logic [4:0]         DEGREE_RST = 5'd7;
  localparam logic signed [23:0] OFFSET_RST = 24'sd0;
  localparam logic signed [23:0] SCALE_RST  = 24'sd229376;

  localparam logic [1:0] CFG_DEGREE = 2'd0;
  localparam logic [1:0] CFG_OFFSET = 2'd1;
  localparam logic [1:0] CFG_SCALE  = 2'd2;

  localparam logic [31:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [31:0] VAL_MIN = 32'h8000_0000;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint          ONE_Q30 = 64'sd1073741824;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROM,
    ST_MUL,
    ST_NODE,
    ST_DIV,
    ST_FIN,
    ST_FDIV,
    ST_OUT
  } cbb_state_e;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] iters;
    logic [DIV_W-1:0] dividend;  // left aligned: top iters bits are the value
    logic [DIV_W-1:0] divisor;
  } cbb_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } cbb_div_rsp_t;

  // Bitwise long division, used only on constants while building the ROM
  function automatic longint unsigned udiv_f(input longint unsigned a,
                                             input longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int bi = 63; bi >= 0; bi--) begin
      r = {r[62:0], a[bi]};
      if (r >= b) begin
        r = r - b;
        q[bi] = 1'b1;
      end
    end
    return q;
  endfunction

  // cos(k*pi/n) in Q30: fold to the first quadrant, Horner series to t^10/10!
  function automatic longint cos_q30_f(input int unsigned k_in, input int unsigned n);
    int unsigned     k;
    logic            neg;
    longint unsigned t;
    longint unsigned x2;
    longint          p;
    longint          prod;
    k   = k_in;
    neg = 1'b0;
    p   = ONE_Q30;
    if (2 * k > n) begin
      k   = n - k;
      neg = 1'b1;
    end
    t  = udiv_f(64'(k) * PI_Q30, 64'(n));
    x2 = (t * t) >> 30;
    for (int j = 0; j < 5; j++) begin
      prod = longint'(x2) * p;
      case (j)
        0:       p = ONE_Q30 - (prod >>> 30) / 64'sd90;
        1:       p = ONE_Q30 - (prod >>> 30) / 64'sd56;
        2:       p = ONE_Q30 - (prod >>> 30) / 64'sd30;
        3:       p = ONE_Q30 - (prod >>> 30) / 64'sd12;
        default: p = ONE_Q30 - (prod >>> 30) / 64'sd2;
      endcase
    end
    return neg ? -p : p;
  endfunction

  // ROM word: cosine rounded half up to frac fraction bits
  function automatic longint cos_node_f(input int unsigned k, input int unsigned n,
                                        input int unsigned frac);
    longint c;
    c = cos_q30_f(k, n) + (longint'(1) <<< (29 - frac));
    return c >>> (30 - frac);
  endfunction

endpackage

@@ hw/rtl/cbb_cos_rom.sv @@
// Cosine ROM indexed by degree and node step, with registered read data.
module cbb_cos_rom #(
  parameter int unsigned MAX_DEGREE = cbb_pkg::MAX_DEGREE_DEF,
  parameter int unsigned FRAC_BITS  = cbb_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic [$clog2(MAX_DEGREE+1)-1:0]    degree_i,
  input  logic [$clog2(MAX_DEGREE+1)-1:0]    step_i,
  output logic signed [FRAC_BITS+1:0]        cos_o
);
  import cbb_pkg::*;

  localparam int unsigned CW = FRAC_BITS + 2;

  logic signed [CW-1:0] rom_w [MAX_DEGREE+1][MAX_DEGREE+1];
  logic signed [CW-1:0] cos_q;

  for (genvar gn = 0; gn <= MAX_DEGREE; gn++) begin : g_deg
    for (genvar gk = 0; gk <= MAX_DEGREE; gk++) begin : g_step
      if (gn >= 1 && gk <= gn) begin : g_word
        assign rom_w[gn][gk] = CW'(cos_node_f(gk, gn, FRAC_BITS));
      end else begin : g_unused
        assign rom_w[gn][gk] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q <= rom_w[degree_i][step_i];
  end

  assign cos_o = cos_q;

endmodule

@@ hw/rtl/cbb_div.sv @@
// Shared restoring divider, one quotient bit per cycle on unsigned magnitudes.
module cbb_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cbb_pkg::cbb_div_req_t req_i,
  output cbb_pkg::cbb_div_rsp_t rsp_o
);
  import cbb_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] dsr_q, dsr_d;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W+1:0] diff;

  always_comb begin
    rem_sh = {rem_q, quo_q[DIV_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.iters;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      // quotient bits shift in from the bottom as dividend bits leave the top
      quo_d = {quo_q[DIV_W-2:0], ~diff[DIV_W+1]};
      rem_d = diff[DIV_W+1] ? rem_sh[DIV_W-1:0] : diff[DIV_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ hw/rtl/chebyshev_barycentric_basis_core.sv @@
// Barycentric Lagrange basis on Chebyshev-Lobatto nodes, one item at a time.
// Each node takes a ROM read, a multiply, a node compare and a reciprocal division in the
// shared serial divider (one quotient bit per cycle); a final division forms the result
// unless the basis index exceeds the degree or the weight sum is zero; x hitting a node ends it early.
// A new item is taken once the result is taken.
// Reset: async active low; sequencer idles, registers return to degree 7, offset 0, scale 3.5.
module chebyshev_barycentric_basis_core #(
  parameter int unsigned MAX_DEGREE = cbb_pkg::MAX_DEGREE_DEF,
  parameter int unsigned FRAC_BITS  = cbb_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] x_position
  input  logic [4:0]  s_axis_tuser,   // [4:0] basis_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] basis_value
  output logic [1:0]  m_axis_tuser    // [0] on_node, [1] saturated
);
  import cbb_pkg::*;

  localparam int unsigned DEG_W   = $clog2(MAX_DEGREE + 1);
  localparam int unsigned IW      = (DEG_W > 5) ? DEG_W : 5;
  localparam int unsigned CW      = FRAC_BITS + 2;
  localparam int unsigned SUM_W   = ((CW > 24) ? CW : 24) + 1;
  localparam int unsigned PROD_W  = SUM_W + 24;
  localparam int unsigned NODE_W  = PROD_W + 1;
  localparam int unsigned DIFF_W  = PROD_W + 2;

  localparam logic [CNT_W-1:0]        RECIP_ITERS = CNT_W'(63 - FRAC_BITS);
  localparam logic [CNT_W-1:0]        FINAL_ITERS = CNT_W'(63);
  localparam logic [DIV_W-1:0]        RECIP_FULL  = DIV_W'(1) << (DIV_W - 1);
  localparam logic [DIV_W-1:0]        RECIP_HALF  = DIV_W'(1) << (DIV_W - 2);
  localparam logic signed [NODE_W-1:0] ROUND_HALF = NODE_W'(1) <<< (FRAC_BITS - 1);
  localparam logic [IW-1:0]           MAX_DEG_IW  = IW'(MAX_DEGREE);
  localparam logic [31:0]             VAL_ONE     = 32'(1) << FRAC_BITS;

  cbb_state_e state_q, state_d;

  logic [4:0]         degree_q;
  logic signed [23:0] offset_q;
  logic signed [23:0] scale_q;

  logic signed [23:0] x_q, x_d;
  logic [4:0]         m_q, m_d;
  logic [DEG_W-1:0]   n_q, n_d;
  logic [DEG_W-1:0]   i_q, i_d;
  logic signed [DIV_W-1:0] num_q, num_d;
  logic signed [DIV_W-1:0] den_q, den_d;
  logic               d_neg_q, d_neg_d;
  logic               q_neg_q, q_neg_d;
  logic [31:0]        value_q, value_d;
  logic               hit_q, hit_d;
  logic               sat_q, sat_d;

  logic signed [CW-1:0]     cos_w;
  logic signed [SUM_W-1:0]  sum_w;
  logic signed [PROD_W-1:0] prod_w;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [NODE_W-1:0] node_w;
  logic signed [DIFF_W-1:0] diff_w;
  logic signed [DIFF_W-1:0] d_mag;
  logic                     hit_w;
  logic                     is_end;
  logic [IW-1:0]            deg_ext, n_clamp, i_ext, n_ext, m_ext;
  logic signed [DIV_W-1:0]  quot_s, r_w;
  logic [DIV_W-1:0]         num_mag, den_mag, q_mag;

  cbb_div_req_t div_req;
  cbb_div_rsp_t div_rsp;

  cbb_cos_rom #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_rom (
    .clk_i    (clk_i),
    .degree_i (n_q),
    .step_i   (n_q - i_q),
    .cos_o    (cos_w)
  );

  cbb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Node: ((cos + offset) * scale) rounded half up
  assign sum_w  = SUM_W'(cos_w) + SUM_W'(offset_q);
  assign prod_w = PROD_W'(sum_w) * PROD_W'(scale_q);
  assign node_w = (NODE_W'(prod_q) + ROUND_HALF) >>> FRAC_BITS;
  assign hit_w  = (node_w == NODE_W'(x_q));
  assign diff_w = DIFF_W'(x_q) - DIFF_W'(node_w);
  assign d_mag  = diff_w[DIFF_W-1] ? -diff_w : diff_w;
  assign is_end = (i_q == '0) || (i_q == n_q);

  assign deg_ext = IW'(degree_q);
  assign n_clamp = (deg_ext == '0) ? IW'(1) : ((deg_ext > MAX_DEG_IW) ? MAX_DEG_IW : deg_ext);
  assign i_ext   = IW'(i_q);
  assign n_ext   = IW'(n_q);
  assign m_ext   = IW'(m_q);

  // Term sign: divisor sign, flipped on odd nodes
  assign quot_s  = $signed(div_rsp.quotient);
  assign r_w     = (d_neg_q ^ i_q[0]) ? -quot_s : quot_s;
  assign num_mag = num_q[DIV_W-1] ? DIV_W'(-num_q) : DIV_W'(num_q);
  assign den_mag = den_q[DIV_W-1] ? DIV_W'(-den_q) : DIV_W'(den_q);
  assign q_mag   = div_rsp.quotient;

  always_comb begin
    state_d       = state_q;
    x_d           = x_q;
    m_d           = m_q;
    n_d           = n_q;
    i_d           = i_q;
    num_d         = num_q;
    den_d         = den_q;
    d_neg_d       = d_neg_q;
    q_neg_d       = q_neg_q;
    value_d       = value_q;
    hit_d         = hit_q;
    sat_d         = sat_q;
    div_req       = '0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          x_d     = s_axis_tdata;
          m_d     = s_axis_tuser;
          n_d     = n_clamp[DEG_W-1:0];
          i_d     = '0;
          num_d   = '0;
          den_d   = '0;
          hit_d   = 1'b0;
          sat_d   = 1'b0;
          state_d = ST_ROM;
        end
      end
      ST_ROM: state_d = ST_MUL;
      ST_MUL: state_d = ST_NODE;
      ST_NODE: begin
        if (hit_w) begin
          // first node equal to x decides the item
          hit_d   = 1'b1;
          value_d = (i_ext == m_ext) ? VAL_ONE : '0;
          state_d = ST_OUT;
        end else begin
          div_req.start    = 1'b1;
          div_req.iters    = RECIP_ITERS;
          div_req.dividend = is_end ? RECIP_HALF : RECIP_FULL;
          div_req.divisor  = DIV_W'(d_mag);
          d_neg_d          = diff_w[DIFF_W-1];
          state_d          = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          den_d = den_q + r_w;
          if (i_ext == m_ext) begin
            num_d = r_w;
          end
          if (i_q == n_q) begin
            state_d = ST_FIN;
          end else begin
            i_d     = i_q + DEG_W'(1);
            state_d = ST_ROM;
          end
        end
      end
      ST_FIN: begin
        if (m_ext > n_ext) begin
          value_d = '0;
          state_d = ST_OUT;
        end else if (den_q == '0) begin
          if (num_q == '0) begin
            value_d = '0;
          end else begin
            value_d = num_q[DIV_W-1] ? VAL_MIN : VAL_MAX;
            sat_d   = 1'b1;
          end
          state_d = ST_OUT;
        end else begin
          div_req.start    = 1'b1;
          div_req.iters    = FINAL_ITERS;
          div_req.dividend = num_mag << (FRAC_BITS + 1);
          div_req.divisor  = den_mag;
          q_neg_d          = num_q[DIV_W-1] ^ den_q[DIV_W-1];
          state_d          = ST_FDIV;
        end
      end
      ST_FDIV: begin
        if (div_rsp.done) begin
          if (!q_neg_q) begin
            if (q_mag > DIV_W'(VAL_MAX)) begin
              value_d = VAL_MAX;
              sat_d   = 1'b1;
            end else begin
              value_d = q_mag[31:0];
            end
          end else begin
            if (q_mag > DIV_W'(VAL_MIN)) begin
              value_d = VAL_MIN;
              sat_d   = 1'b1;
            end else begin
              value_d = 32'd0 - q_mag[31:0];
            end
          end
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= DEGREE_RST;
      offset_q <= OFFSET_RST;
      scale_q  <= SCALE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DEGREE: degree_q <= cfg_data_i[4:0];
        CFG_OFFSET: offset_q <= cfg_data_i;
        CFG_SCALE:  scale_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    m_q     <= m_d;
    n_q     <= n_d;
    num_q   <= num_d;
    den_q   <= den_d;
    d_neg_q <= d_neg_d;
    q_neg_q <= q_neg_d;
    value_q <= value_d;
    hit_q   <= hit_d;
    sat_q   <= sat_d;
    prod_q  <= prod_w;
  end

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = value_q;
  assign m_axis_tuser = {sat_q, hit_q};

endmodule

@@ tb/chebyshev_barycentric_basis_core_tb.sv @@
// Self-checking testbench for the Chebyshev-Lobatto barycentric basis evaluator.
`timescale 1ns / 100ps

module chebyshev_barycentric_basis_core_tb;

  localparam int unsigned FRAC     = cbb_pkg::FRAC_BITS_DEF;
  localparam int unsigned MAX_DEG  = cbb_pkg::MAX_DEGREE_DEF;
  localparam int unsigned RECIP_SH = 62 - FRAC;
  localparam longint      ONE_FIX  = 64'sd1 <<< FRAC;
  localparam longint      VAL_HI   = 64'sd2147483647;
  localparam longint      VAL_LO   = -64'sd2147483648;
  localparam longint      X_HI     = 64'sd8388607;
  localparam longint      X_LO     = -64'sd8388608;

  // index 3 is decoded to nothing
  localparam logic [1:0]  CFG_SPARE = 2'd3;

  localparam int RAND_ITEMS    = 500;
  localparam int SETTLE_CYCLES = 2000;
  localparam int TIMEOUT_NS    = 50_000_000;
  localparam int PRINT_CAP     = 40;

  typedef struct packed {
    logic [31:0] value;
    logic        on_node;
    logic        sat;
  } basis_res_t;

  typedef struct packed {
    logic               is_cfg;
    logic [1:0]         idx;
    logic [23:0]        data;
    logic signed [23:0] x;
    logic [4:0]         m;
    logic               known;
    basis_res_t         want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [23:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;  // [23:0] x_position
  logic [4:0]  s_axis_tuser  = '0;  // [4:0] basis_index
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] basis_value
  logic [1:0]  m_axis_tuser;        // [0] on_node, [1] saturated

  // predictor copy of the registers
  logic [4:0]         deg_reg    = cbb_pkg::DEGREE_RST;
  logic signed [23:0] offset_reg = cbb_pkg::OFFSET_RST;
  logic signed [23:0] scale_reg  = cbb_pkg::SCALE_RST;

  basis_res_t basis_q[$];
  basis_res_t pending;
  stim_row_t  dir_rows[$];

  int          err_count  = 0;
  int          items_sent = 0;
  int          hits_seen  = 0;
  int          sat_seen   = 0;
  int          reg_writes = 0;
  int          rand_items = 0;
  logic [31:0] deg_seen   = '0;
  int          rdy_hold   = 0;

  chebyshev_barycentric_basis_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", basis_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor

  function automatic int unsigned eff_degree();
    int unsigned n;
    n = deg_reg;
    if (n < 1) n = 1;
    if (n > MAX_DEG) n = MAX_DEG;
    return n;
  endfunction

  // cos(k*pi/n) in Q30, folded to the first quadrant, Taylor terms to t^10
  function automatic longint cheb_cos_q30(input int unsigned k_in, input int unsigned n);
    int unsigned     k;
    logic            neg;
    longint unsigned t;
    longint unsigned t2;
    longint          p;
    k   = k_in;
    neg = 1'b0;
    if (2 * k > n) begin
      k   = n - k;
      neg = 1'b1;
    end
    t  = (64'(k) * cbb_pkg::PI_Q30) / 64'(n);
    t2 = (t * t) >> 30;
    p  = cbb_pkg::ONE_Q30;
    // divisors 90, 56, 30, 12, 2
    for (int j = 0; j < 5; j++) begin
      p = cbb_pkg::ONE_Q30 - ((longint'(t2) * p) >>> 30) / longint'((10 - 2 * j) * (9 - 2 * j));
    end
    return neg ? -p : p;
  endfunction

  function automatic longint node_pos(input int unsigned i, input int unsigned n);
    longint c;
    longint p;
    c = (cheb_cos_q30(n - i, n) + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
    p = (c + longint'(offset_reg)) * longint'(scale_reg);
    return (p + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic basis_res_t eval_basis(input logic signed [23:0] x_in,
                                            input logic [4:0] m_in);
    int unsigned n;
    longint      x;
    longint      xj;
    longint      d;
    longint      r;
    longint      num;
    longint      den;
    longint      q;
    logic        hit;
    basis_res_t  res;
    res = '0;
    n   = eff_degree();
    x   = longint'(x_in);
    num = 0;
    den = 0;
    hit = 1'b0;
    for (int i = 0; i <= n; i++) begin
      if (!hit) begin
        xj = node_pos(i, n);
        if (x == xj) begin
          // first matching node wins, even when nodes coincide
          hit         = 1'b1;
          res.on_node = 1'b1;
          res.value   = (i == m_in) ? 32'(ONE_FIX) : '0;
        end else begin
          d = x - xj;
          r = (64'sd1 <<< ((i == 0 || i == n) ? RECIP_SH - 1 : RECIP_SH)) / d;
          if (i % 2 == 1) r = -r;
          den += r;
          if (i == m_in) num = r;
        end
      end
    end
    if (!hit && m_in <= n) begin
      if (den == 0) begin
        if (num > 0) begin
          res.value = cbb_pkg::VAL_MAX;
          res.sat   = 1'b1;
        end else if (num < 0) begin
          res.value = cbb_pkg::VAL_MIN;
          res.sat   = 1'b1;
        end
      end else begin
        q = (num * ONE_FIX) / den;
        if (q > VAL_HI) begin
          q       = VAL_HI;
          res.sat = 1'b1;
        end else if (q < VAL_LO) begin
          q       = VAL_LO;
          res.sat = 1'b1;
        end
        res.value = q[31:0];
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Random choices

  function automatic int unsigned gap_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [4:0] pick_degree();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 5'($urandom_range(1, 6));
    if (r < 75) return 5'($urandom_range(7, 12));
    if (r < 85) return 5'($urandom_range(13, 20));
    if (r < 92) return 5'($urandom_range(0, 1));
    return 5'($urandom_range(21, 31));
  endfunction

  function automatic logic [23:0] pick_offset();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return '0;
    if (r < 75) return 24'(int'($urandom_range(0, 131072)) - 65536);
    if (r < 90) return 24'($urandom());
    return (r % 2 == 0) ? 24'h7fffff : 24'h800000;
  endfunction

  function automatic logic [23:0] pick_scale();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 24'($urandom_range(16384, 524288));
    if (r < 60) return 24'(-int'($urandom_range(16384, 524288)));
    if (r < 75) return 24'($urandom());
    if (r < 85) return (r % 2 == 0) ? 24'h7fffff : 24'h800000;
    if (r < 90) return '0;
    return 24'($urandom_range(1, 255));
  endfunction

  // mostly exact node hits, near misses and points inside the node span
  function automatic logic signed [23:0] pick_x(input int unsigned n);
    int unsigned r;
    longint      v;
    longint      lo;
    longint      hi;
    longint      tmp;
    r  = $urandom_range(0, 99);
    lo = node_pos(0, n);
    hi = node_pos(n, n);
    if (lo > hi) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    if (r < 35) begin
      v = node_pos($urandom_range(0, n), n);
    end else if (r < 60) begin
      v = node_pos($urandom_range(0, n), n) + longint'($urandom_range(0, 200)) - 100;
    end else if (r < 85 && hi - lo < 64'sd4000000000) begin
      v = lo + longint'($urandom_range(0, 32'(hi - lo)));
    end else begin
      v = longint'($signed(24'($urandom())));
    end
    if (v > X_HI || v < X_LO) v = longint'($signed(24'($urandom())));
    return v[23:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus table

  function automatic void add_cfg(input logic [1:0] idx, input logic [23:0] data);
    stim_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_item(input logic signed [23:0] x, input logic [4:0] m);
    stim_row_t row;
    row   = '0;
    row.x = x;
    row.m = m;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_known(input logic signed [23:0] x, input logic [4:0] m,
                                    input logic [31:0] value, input logic on_node,
                                    input logic sat);
    stim_row_t row;
    row            = '0;
    row.x          = x;
    row.m          = m;
    row.known      = 1'b1;
    row.want.value = value;
    row.want.on_node = on_node;
    row.want.sat   = sat;
    dir_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (basis_q.size() != 0);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    reg_writes++;
    case (idx)
      cbb_pkg::CFG_DEGREE: deg_reg    = data[4:0];
      cbb_pkg::CFG_OFFSET: offset_reg = data;
      cbb_pkg::CFG_SCALE:  scale_reg  = data;
      default: ;
    endcase
  endtask

  task automatic send_item(input logic signed [23:0] x, input logic [4:0] m,
                           input logic known, input basis_res_t want);
    int unsigned gap;
    gap = gap_cycles();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    s_axis_tuser  <= m;
    do @(posedge clk_i); while (!s_axis_tready);
    basis_q.push_back(known ? want : eval_basis(x, m));
    deg_seen[eff_degree()] = 1'b1;
    items_sent++;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < PRINT_CAP)
      $display("MISMATCH @%0t %s: got %h, want %h", $time, what, got, want);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls with long stretches of ready

  always @(posedge clk_i) begin
    if (rdy_hold != 0) begin
      rdy_hold <= rdy_hold - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      rdy_hold      <= gap_cycles();
    end else begin
      m_axis_tready <= 1'b1;
      rdy_hold      <= ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8)
                                                   : $urandom_range(20, 200);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (basis_q.size() == 0) begin
        report_mismatch("result with nothing pending", m_axis_tdata, '0);
      end else begin
        pending = basis_q.pop_front();
        if (m_axis_tdata !== pending.value)
          report_mismatch("basis_value", m_axis_tdata, pending.value);
        if (m_axis_tuser[0] !== pending.on_node)
          report_mismatch("on_node", 32'(m_axis_tuser[0]), 32'(pending.on_node));
        if (m_axis_tuser[1] !== pending.sat)
          report_mismatch("saturated", 32'(m_axis_tuser[1]), 32'(pending.sat));
        hits_seen += m_axis_tuser[0];
        sat_seen  += m_axis_tuser[1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence

  initial begin
    int unsigned n;
    int unsigned count;
    logic [4:0]  m;

    // reset nodes: degree 7, scale 3.5, ends at -3.5 and +3.5
    add_known(-24'sd229376, 5'd0, 32'h0001_0000, 1'b1, 1'b0);
    add_known(24'sd229376, 5'd7, 32'h0001_0000, 1'b1, 1'b0);
    add_known(24'sd229376, 5'd0, 32'h0000_0000, 1'b1, 1'b0);
    add_known(24'sd0, 5'd31, 32'h0000_0000, 1'b0, 1'b0);
    add_item(24'sh7fffff, 5'd3);
    add_item(24'sh800000, 5'd0);
    add_item(24'sd1, 5'd4);
    add_item(24'sd12345, 5'd7);
    // degree 0 acts as 1; zero scale stacks both nodes at 0, so the sum cancels
    add_cfg(cbb_pkg::CFG_DEGREE, 24'd0);
    add_cfg(cbb_pkg::CFG_SCALE, 24'd0);
    add_known(24'sd1, 5'd0, cbb_pkg::VAL_MAX, 1'b0, 1'b1);
    add_known(24'sd1, 5'd1, cbb_pkg::VAL_MIN, 1'b0, 1'b1);
    add_known(24'sd0, 5'd1, 32'h0000_0000, 1'b1, 1'b0);
    add_known(24'sd0, 5'd0, 32'h0001_0000, 1'b1, 1'b0);
    add_cfg(CFG_SPARE, 24'hffffff);
    add_known(24'sd5, 5'd0, cbb_pkg::VAL_MAX, 1'b0, 1'b1);
    // upper data bits of the degree write are dropped: degree 31
    add_cfg(cbb_pkg::CFG_DEGREE, 24'hffffff);
    add_cfg(cbb_pkg::CFG_OFFSET, 24'h800000);
    add_cfg(cbb_pkg::CFG_SCALE, 24'h7fffff);
    add_item(24'sd0, 5'd15);
    add_item(24'sh7fffff, 5'd31);
    add_item(24'sh800000, 5'd30);
    add_cfg(cbb_pkg::CFG_OFFSET, 24'h7fffff);
    add_cfg(cbb_pkg::CFG_SCALE, 24'h800000);
    add_item(24'sd0, 5'd16);
    add_item(24'sd1, 5'd0);
    // degree 2 on [-1, 1]
    add_cfg(cbb_pkg::CFG_DEGREE, 24'd2);
    add_cfg(cbb_pkg::CFG_OFFSET, 24'd0);
    add_cfg(cbb_pkg::CFG_SCALE, 24'd65536);
    add_item(24'sd0, 5'd1);
    add_known(24'sd65536, 5'd2, 32'h0001_0000, 1'b1, 1'b0);
    add_known(-24'sd65536, 5'd2, 32'h0000_0000, 1'b1, 1'b0);
    add_known(24'sd3, 5'd3, 32'h0000_0000, 1'b0, 1'b0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg)
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      else
        send_item(dir_rows[i].x, dir_rows[i].m, dir_rows[i].known, dir_rows[i].want);
    end

    while (rand_items < RAND_ITEMS) begin
      write_reg(cbb_pkg::CFG_DEGREE, {19'($urandom()), pick_degree()});
      write_reg(cbb_pkg::CFG_OFFSET, pick_offset());
      write_reg(cbb_pkg::CFG_SCALE, pick_scale());
      if ($urandom_range(0, 5) == 0) write_reg(CFG_SPARE, 24'($urandom()));
      n = eff_degree();
      // high degrees are slow, keep those phases short
      count = (n >= 16) ? 6 : 30;
      for (int k = 0; k < count; k++) begin
        if ($urandom_range(0, 39) == 0) begin
          s_axis_tvalid <= 1'b0;
          do @(posedge clk_i); while (basis_q.size() != 0);
        end
        m = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, n)) : 5'($urandom());
        send_item(pick_x(n), m, 1'b0, '0);
        rand_items++;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (basis_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d items over %0d degrees: %0d node hits, %0d clipped results",
             items_sent, $countones(deg_seen), hits_seen, sat_seen);
    $display("%0d register writes, %0d mismatches", reg_writes, err_count);
    if (err_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
